FILE: src/multi_slot_timer_table_macros.svh
// assertion helpers for the timer table top module
`ifndef MULTI_SLOT_TIMER_TABLE_MACROS_SVH
`define MULTI_SLOT_TIMER_TABLE_MACROS_SVH

// condition that must hold on every clock edge out of reset
`define MSTT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must be followed by another one on the next edge
`define MSTT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/mstt_pkg.sv
package mstt_pkg;

	localparam int SLOTS     = 8;
	localparam int TICK_BITS = 32;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int CMP_W     = (TICK_BITS > 32) ? TICK_BITS : 32;

	localparam logic [2:0] KIND_REG   = 3'd0;
	localparam logic [2:0] KIND_UNREG = 3'd1;
	localparam logic [2:0] KIND_TICK  = 3'd2;
	localparam logic [2:0] KIND_SCAN  = 3'd3;
	localparam logic [2:0] KIND_RTICK = 3'd4;

	localparam logic [1:0] MODE_PERIODIC = 2'd0;
	localparam logic [1:0] MODE_ONESHOT  = 2'd1;
	localparam logic [1:0] MODE_EVERY    = 2'd2;

	localparam logic [1:0] RES_DONE  = 2'd0;
	localparam logic [1:0] RES_FULL  = 2'd1;
	localparam logic [1:0] RES_FIRED = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] tmr_id;
		logic [31:0] timeout_ticks;
		logic [1:0]  timer_mode;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] fired_id;
		logic [31:0] fired_timeout;
		logic [3:0]  active_count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic                 set;
		logic                 clr;
		logic                 adv;
		logic [IDX_W-1:0]     idx;
		logic [31:0]          id;
		logic [31:0]          timeout;
		logic [1:0]           mode;
		logic [TICK_BITS-1:0] start;
	} slot_wr_t;

	typedef struct packed {
		logic                 valid;
		logic [31:0]          id;
		logic [31:0]          timeout;
		logic [1:0]           mode;
		logic [TICK_BITS-1:0] start;
	} slot_rd_t;

endpackage

FILE: src/mstt_alu.sv
module mstt_alu (
	input  logic [mstt_pkg::TICK_BITS-1:0] tick,
	input  logic [mstt_pkg::TICK_BITS-1:0] start_tick,
	input  logic [31:0]                    timeout,
	output logic                           expired,
	output logic [mstt_pkg::TICK_BITS-1:0] next_start
);
	import mstt_pkg::*;

	logic [TICK_BITS-1:0] elapsed;
	logic [CMP_W-1:0]     sum;

	// modular elapsed time, compared against the timeout at the wider width
	assign elapsed    = tick - start_tick;
	assign expired    = CMP_W'(elapsed) > CMP_W'(timeout);
	assign sum        = CMP_W'(start_tick) + CMP_W'(timeout);
	assign next_start = sum[TICK_BITS-1:0];

endmodule

FILE: src/mstt_slots.sv
module mstt_slots (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mstt_pkg::slot_wr_t          wr,
	input  logic [mstt_pkg::IDX_W-1:0]  rd_idx,
	output mstt_pkg::slot_rd_t          rd
);
	import mstt_pkg::*;

	logic [SLOTS-1:0]     valid_q;
	logic [31:0]          id_q      [SLOTS];
	logic [31:0]          timeout_q [SLOTS];
	logic [1:0]           mode_q    [SLOTS];
	logic [TICK_BITS-1:0] start_q   [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.set) begin
			valid_q[wr.idx] <= 1'b1;
		end else if (wr.clr) begin
			valid_q[wr.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.set) begin
			id_q[wr.idx]      <= wr.id;
			timeout_q[wr.idx] <= wr.timeout;
			mode_q[wr.idx]    <= wr.mode;
		end
		if (wr.set || wr.adv) begin
			start_q[wr.idx] <= wr.start;
		end
	end

	assign rd.valid   = valid_q[rd_idx];
	assign rd.id      = id_q[rd_idx];
	assign rd.timeout = timeout_q[rd_idx];
	assign rd.mode    = mode_q[rd_idx];
	assign rd.start   = start_q[rd_idx];

endmodule

FILE: src/multi_slot_timer_table.sv
// channel   direction  handshake              payload
// command   in         start high, busy low   cmd (cmd_t)
// result    out        strobe, one cycle      result (result_t)
//
// tick, reset-tick, unknown kinds, a full or id-zero register and an id-zero
// unregister: result in the cycle after the item, busy stays low.
// register / unregister: one slot per cycle through the single slot read port,
// busy until the search ends and the done state gives the final result.
// scan: an evaluate pass over the slots through the compare unit, then an emit
// pass that gives a result per fired slot, then the done state.
// asynchronous reset clears slot valid bits, count and tick at once.
// the receiver cannot stall: each result is shown for exactly one cycle.
module multi_slot_timer_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mstt_pkg::cmd_t    cmd,
	output logic              strobe,
	output mstt_pkg::result_t result
);
	import mstt_pkg::*;

	`include "multi_slot_timer_table_macros.svh"

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_EVAL   = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]           state_q, state_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [CNT_W-1:0]     occ_q, occ_d;
	logic [TICK_BITS-1:0] tick_q, tick_d;
	logic [SLOTS-1:0]     fire_q, fire_d;
	logic                 strobe_q, emit;
	cmd_t                 item_q, item_d;
	result_t              result_q, res_d;
	slot_wr_t             wr;
	slot_rd_t             rd;
	logic                 expired;
	logic [TICK_BITS-1:0] next_start;
	logic                 idx_last;
	logic                 accept;
	logic                 fire;

	mstt_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (idx_q),
		.rd     (rd)
	);

	mstt_alu u_alu (
		.tick       (tick_q),
		.start_tick (rd.start),
		.timeout    (rd.timeout),
		.expired    (expired),
		.next_start (next_start)
	);

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign idx_last = (idx_q == IDX_W'(SLOTS - 1));
	assign fire     = rd.valid && ((rd.mode == MODE_EVERY) ||
		(((rd.mode == MODE_PERIODIC) || (rd.mode == MODE_ONESHOT)) && expired));

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		occ_d   = occ_q;
		tick_d  = tick_q;
		fire_d  = fire_q;
		item_d  = item_q;
		emit    = 1'b0;
		res_d   = '0;
		wr      = '0;
		wr.idx  = idx_q;
		res_d.active_count = 4'(occ_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_d = cmd;
					unique case (cmd.kind)
						KIND_REG: begin
							if (occ_q >= CNT_W'(SLOTS)) begin
								emit              = 1'b1;
								res_d.result_kind = RES_FULL;
								res_d.last        = 1'b1;
							end else if (cmd.tmr_id == '0) begin
								emit       = 1'b1;
								res_d.last = 1'b1;
							end else begin
								state_d = ST_SEARCH;
								idx_d   = '0;
							end
						end
						KIND_UNREG: begin
							if (cmd.tmr_id == '0) begin
								emit       = 1'b1;
								res_d.last = 1'b1;
							end else begin
								state_d = ST_SEARCH;
								idx_d   = '0;
							end
						end
						KIND_TICK: begin
							tick_d     = tick_q + 1'b1;
							emit       = 1'b1;
							res_d.last = 1'b1;
						end
						KIND_SCAN: begin
							state_d = ST_EVAL;
							idx_d   = '0;
						end
						KIND_RTICK: begin
							tick_d     = '0;
							emit       = 1'b1;
							res_d.last = 1'b1;
						end
						default: begin
							emit       = 1'b1;
							res_d.last = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (item_q.kind == KIND_REG) begin
					// first free slot takes the timer
					if (!rd.valid) begin
						wr.set     = 1'b1;
						wr.id      = item_q.tmr_id;
						wr.timeout = item_q.timeout_ticks;
						wr.mode    = item_q.timer_mode;
						wr.start   = tick_q;
						occ_d      = occ_q + 1'b1;
						state_d    = ST_DONE;
					end else if (idx_last) begin
						state_d = ST_DONE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end else begin
					if (rd.valid && (rd.id == item_q.tmr_id)) begin
						wr.clr = 1'b1;
						occ_d  = occ_q - 1'b1;
					end
					if (idx_last) begin
						state_d = ST_DONE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_EVAL: begin
				// updates go in now so the count is final before any result
				fire_d[idx_q] = fire;
				if (rd.valid && expired && (rd.mode == MODE_PERIODIC)) begin
					wr.adv   = 1'b1;
					wr.start = next_start;
				end
				if (rd.valid && expired && (rd.mode == MODE_ONESHOT)) begin
					wr.clr = 1'b1;
					occ_d  = occ_q - 1'b1;
				end
				if (idx_last) begin
					state_d = ST_EMIT;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_EMIT: begin
				// id and timeout stay in the slot even after a one-shot frees it
				if (fire_q[idx_q]) begin
					emit                = 1'b1;
					res_d.result_kind   = RES_FIRED;
					res_d.fired_id      = rd.id;
					res_d.fired_timeout = rd.timeout;
				end
				if (idx_last) begin
					state_d = ST_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DONE: begin
				emit       = 1'b1;
				res_d.last = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			occ_q    <= '0;
			tick_q   <= '0;
			fire_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			occ_q    <= occ_d;
			tick_q   <= tick_d;
			fire_q   <= fire_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		item_q   <= item_d;
		result_q <= res_d;
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`MSTT_ASSERT(a_occ_range, occ_q <= CNT_W'(SLOTS), "slot count above table size")
	`MSTT_ASSERT_NEXT(a_scan_busy, accept && (cmd.kind == KIND_SCAN), busy,
		"scan item did not start the sequencer")
	`MSTT_ASSERT(a_last_idle, !(strobe && result.last) || !busy,
		"final result while sequencer still busy")
	`MSTT_ASSERT(a_mid_busy, !(strobe && !result.last) || busy,
		"non-final result outside a scan")
	`MSTT_ASSERT(a_fired_id, !(strobe && (result.result_kind == RES_FIRED)) ||
		(result.fired_id != '0), "fired result with id zero")

endmodule
